// ===== rtl/fpsr_pkg.sv =====
// Shared types and constants for the fronthaul packet steering block.
// Used by the register bank, the steering logic, the top level and the checker.
package fpsr_pkg;

	localparam int NUM_UNITS = 2;

	localparam int MAC_W    = 48;
	localparam int TCI_W    = 16;
	localparam int VID_W    = 12;
	localparam int MAP_W    = 16;
	localparam int CFG_W    = 56;
	localparam int CFG_IDX_W = 3;

	localparam logic [TCI_W-1:0] PRIO_MASK = 16'hF000;
	localparam logic [TCI_W-1:0] VID_MASK  = 16'h0FFF;
	localparam logic [TCI_W-1:0] PORT_MASK = 16'h000F;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIDDLEBOX_MAC = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DU_MAC        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DU_VLAN_ID    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RU0_MAC       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RU0_LOCAL_MAC = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RU1_MAC       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RU1_LOCAL_MAC = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RU_MAPS       = 3'd7;

	// result action codes
	localparam logic [2:0] ACT_FWD      = 3'd0;
	localparam logic [2:0] ACT_BAD_SRC  = 3'd1;
	localparam logic [2:0] ACT_BAD_DST  = 3'd2;
	localparam logic [2:0] ACT_BAD_TYPE = 3'd3;
	localparam logic [2:0] ACT_NO_ANT   = 3'd4;

	// eCPRI message types
	localparam logic [7:0] TYPE_IQ  = 8'd0;
	localparam logic [7:0] TYPE_RTC = 8'd2;

	// ingress port codes
	localparam logic [1:0] PORT_DU   = 2'd0;
	localparam logic [1:0] PORT_RU0  = 2'd1;
	localparam logic [1:0] PORT_RU1  = 2'd2;
	localparam logic [1:0] PORT_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]       ingress_port;
		logic [MAC_W-1:0] source_mac;
		logic [MAC_W-1:0] dest_mac;
		logic             has_vlan_tag;
		logic [TCI_W-1:0] tag_control;
		logic [7:0]       ecpri_msg_type;
		logic [3:0]       antenna_port;
	} header_t;

	typedef struct packed {
		logic [2:0]       action;
		logic             target_unit;
		logic [MAC_W-1:0] new_dest_mac;
		logic [MAC_W-1:0] new_source_mac;
		logic [TCI_W-1:0] new_tag_control;
		logic             last_copy;
	} result_t;

	typedef struct packed {
		logic [MAC_W-1:0] middlebox_mac;
		logic [MAC_W-1:0] du_mac;
		logic [VID_W-1:0] du_vlan_id;
		logic [MAC_W-1:0] ru0_mac;
		logic [MAC_W-1:0] ru0_local_mac;
		logic [MAC_W-1:0] ru1_mac;
		logic [MAC_W-1:0] ru1_local_mac;
		logic [CFG_W-1:0] ru_maps;
	} cfg_t;

	// steering decision for one header: one or two copies
	typedef struct packed {
		logic    two_copies;
		result_t first;
		result_t second;
	} steer_t;

	function automatic logic [TCI_W-1:0] retag(input logic has_tag,
			input logic [TCI_W-1:0] tci, input logic [VID_W-1:0] vid);
		logic [TCI_W-1:0] r;
		r = has_tag ? ((tci & PRIO_MASK) | ({4'd0, vid} & VID_MASK)) : tci;
		return r;
	endfunction

endpackage

// ===== rtl/fpsr_cfg_regs.sv =====
// Configuration register bank for the steering block.
// Depends on fpsr_pkg for the register indexes and the cfg_t layout.
module fpsr_cfg_regs import fpsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_MIDDLEBOX_MAC: cfg_q.middlebox_mac <= wr_data[MAC_W-1:0];
				REG_DU_MAC:        cfg_q.du_mac        <= wr_data[MAC_W-1:0];
				REG_DU_VLAN_ID:    cfg_q.du_vlan_id    <= wr_data[VID_W-1:0];
				REG_RU0_MAC:       cfg_q.ru0_mac       <= wr_data[MAC_W-1:0];
				REG_RU0_LOCAL_MAC: cfg_q.ru0_local_mac <= wr_data[MAC_W-1:0];
				REG_RU1_MAC:       cfg_q.ru1_mac       <= wr_data[MAC_W-1:0];
				REG_RU1_LOCAL_MAC: cfg_q.ru1_local_mac <= wr_data[MAC_W-1:0];
				REG_RU_MAPS:       cfg_q.ru_maps       <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/fpsr_steer.sv =====
// Steering and header rewrite decision for one registered header.
// Pure combinational logic; depends on fpsr_pkg for types and codes.
module fpsr_steer import fpsr_pkg::*; (
	input  header_t hdr,
	input  cfg_t    cfg,
	output steer_t  steer
);

	logic [MAC_W-1:0] u_mac   [2];
	logic [MAC_W-1:0] u_local [2];
	logic [MAP_W-1:0] u_map   [2];
	logic [VID_W-1:0] u_vlan  [2];
	logic             hit     [2];
	logic             two_units;
	logic             up_unit;
	logic             up_valid;
	logic [3:0]       ant;
	result_t          drop;
	result_t          fwd     [2];
	result_t          up_fwd;

	assign two_units = (NUM_UNITS > 1);

	assign u_mac[0]   = cfg.ru0_mac;
	assign u_mac[1]   = cfg.ru1_mac;
	assign u_local[0] = cfg.ru0_local_mac;
	assign u_local[1] = cfg.ru1_local_mac;
	assign u_map[0]   = cfg.ru_maps[15:0];
	assign u_vlan[0]  = cfg.ru_maps[27:16];
	assign u_map[1]   = cfg.ru_maps[43:28];
	assign u_vlan[1]  = cfg.ru_maps[55:44];

	assign ant    = hdr.antenna_port & PORT_MASK[3:0];
	assign hit[0] = u_map[0][ant];
	assign hit[1] = u_map[1][ant] & two_units;

	// port 1 is unit zero, port 2 unit one; port 3 names no unit
	assign up_unit  = hdr.ingress_port[1];
	assign up_valid = (hdr.ingress_port == PORT_RU0) ||
		((hdr.ingress_port == PORT_RU1) && two_units);

	always_comb begin
		drop.action          = ACT_BAD_SRC;
		drop.target_unit     = 1'b0;
		drop.new_dest_mac    = hdr.dest_mac;
		drop.new_source_mac  = hdr.source_mac;
		drop.new_tag_control = hdr.tag_control;
		drop.last_copy       = 1'b1;

		for (int u = 0; u < 2; u++) begin
			fwd[u].action          = ACT_FWD;
			fwd[u].target_unit     = u[0];
			fwd[u].new_dest_mac    = u_mac[u];
			fwd[u].new_source_mac  = u_local[u];
			fwd[u].new_tag_control = retag(hdr.has_vlan_tag, hdr.tag_control, u_vlan[u]);
			fwd[u].last_copy       = 1'b1;
		end

		up_fwd.action          = ACT_FWD;
		up_fwd.target_unit     = up_unit;
		up_fwd.new_dest_mac    = cfg.du_mac;
		up_fwd.new_source_mac  = cfg.middlebox_mac;
		up_fwd.new_tag_control = retag(hdr.has_vlan_tag, hdr.tag_control, cfg.du_vlan_id);
		up_fwd.last_copy       = 1'b1;
	end

	always_comb begin
		steer.two_copies = 1'b0;
		steer.first      = drop;
		steer.second     = fwd[1];

		if (hdr.ingress_port == PORT_DU) begin
			if (hdr.source_mac != cfg.du_mac) begin
				steer.first.action = ACT_BAD_SRC;
			end else if (hdr.dest_mac != cfg.middlebox_mac) begin
				steer.first.action = ACT_BAD_DST;
			end else if (hdr.ecpri_msg_type == TYPE_RTC) begin
				// control goes to every unit, unit zero first
				steer.first = fwd[0];
				if (two_units) begin
					steer.two_copies          = 1'b1;
					steer.first.last_copy     = 1'b0;
				end
			end else if (hdr.ecpri_msg_type == TYPE_IQ) begin
				if (hit[0]) begin
					steer.first = fwd[0];
				end else if (hit[1]) begin
					steer.first = fwd[1];
				end else begin
					steer.first.action = ACT_NO_ANT;
				end
			end else begin
				steer.first.action = ACT_BAD_TYPE;
			end
		end else if (!up_valid) begin
			steer.first.action = ACT_BAD_SRC;
		end else begin
			steer.first.target_unit = up_unit;
			if (hdr.source_mac != u_mac[up_unit]) begin
				steer.first.action = ACT_BAD_SRC;
			end else if (hdr.dest_mac != u_local[up_unit]) begin
				steer.first.action = ACT_BAD_DST;
			end else if (!u_map[up_unit][ant]) begin
				steer.first.action = ACT_NO_ANT;
			end else begin
				steer.first = up_fwd;
			end
		end
	end

endmodule

// ===== rtl/fronthaul_packet_steering_rewrite.sv =====
// Fronthaul packet steering and header rewrite, two radio units.
// A header is taken when start is high and busy is low and held in the input
// register; its results are registered and shown on result with done high, and
// the receiver cannot hold results off. A new header can be taken every cycle
// while busy is low. A well-addressed downlink control header yields one copy
// per radio unit, unit zero first; while it sits in the input register busy is
// high for that one cycle, since the single result port emits one copy per cycle.
// Every other header gives exactly one result; last_copy marks each header's last.
// Configuration registers are written through cfg_valid/cfg_ready (always ready)
// and should be changed only while no header is in flight.
// Depends on fpsr_pkg, fpsr_cfg_regs and fpsr_steer.
module fronthaul_packet_steering_rewrite import fpsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  header_t              header,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t    cfg;
	steer_t  steer;
	logic    valid_s1;
	header_t hdr_s1;
	logic    done_q;
	result_t result_q;
	logic    pend_q;
	result_t pend_data_q;
	logic    accept;

	assign cfg_ready = 1'b1;

	fpsr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	fpsr_steer u_steer (
		.hdr   (hdr_s1),
		.cfg   (cfg),
		.steer (steer)
	);

	// hold off the next item while a two-copy item uses the result port twice
	assign busy   = valid_s1 & steer.two_copies;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_s1 <= header;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			done_q <= valid_s1 | pend_q;
			pend_q <= valid_s1 & steer.two_copies;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q    <= steer.first;
			pend_data_q <= steer.second;
		end else if (pend_q) begin
			result_q <= pend_data_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/fpsr_checker.sv =====
// Port-level assertions for the steering block, bound to its top level.
// Depends on fpsr_pkg for the result type and action codes.
module fpsr_port_checker import fpsr_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// every accepted item shows its first result after the input and result registers
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("accepted item gave no result on time");

	// a first copy that is not the last is followed at once by the next copy
	a_second_copy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last_copy |=> done && result.last_copy)
		else $error("second copy missing after first copy");

	// busy is raised only for an item that expands into copies
	a_busy_copies: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !result.last_copy)
		else $error("busy without a multi-copy item");

	// only forwarded copies come in pairs
	a_pair_forward: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last_copy |-> result.action == ACT_FWD)
		else $error("non-forward result marked as not last");

endmodule

bind fronthaul_packet_steering_rewrite fpsr_port_checker u_fpsr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== bench/fpsr_checker.sv =====
// Checker for the fronthaul packet steering block: watches the header, result and
// register write channels, predicts the rewritten copies and compares them in order.
// Depends on fpsr_pkg for the header, result and register layout.
module fpsr_checker import fpsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  header_t              header,
	input  logic                 done,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 100;

	cfg_t    regs_copy;
	result_t copies_due[$];
	int      mismatches = 0;

	initial fail_count = 0;
	initial pending = 0;

	function automatic logic [MAC_W-1:0] ru_mac(input logic u);
		return u ? regs_copy.ru1_mac : regs_copy.ru0_mac;
	endfunction

	function automatic logic [MAC_W-1:0] ru_local_mac(input logic u);
		return u ? regs_copy.ru1_local_mac : regs_copy.ru0_local_mac;
	endfunction

	function automatic logic [MAP_W-1:0] ru_antenna_map(input logic u);
		return u ? regs_copy.ru_maps[43:28] : regs_copy.ru_maps[15:0];
	endfunction

	function automatic logic [VID_W-1:0] ru_vid(input logic u);
		return u ? regs_copy.ru_maps[55:44] : regs_copy.ru_maps[27:16];
	endfunction

	// keep priority and DEI, swap the VLAN ID; untagged frames pass through
	function automatic logic [TCI_W-1:0] swap_vid(input logic has_tag,
			input logic [TCI_W-1:0] tci, input logic [VID_W-1:0] vid);
		return has_tag ? ((tci & PRIO_MASK) | {4'd0, vid}) : tci;
	endfunction

	function automatic result_t make_copy(input logic [2:0] act, input logic u,
			input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src,
			input logic [TCI_W-1:0] tci, input logic last);
		result_t r;
		r.action          = act;
		r.target_unit     = u;
		r.new_dest_mac    = dst;
		r.new_source_mac  = src;
		r.new_tag_control = tci;
		r.last_copy       = last;
		return r;
	endfunction

	function automatic result_t drop_copy(input logic [2:0] act, input logic u,
			input header_t h);
		return make_copy(act, u, h.dest_mac, h.source_mac, h.tag_control, 1'b1);
	endfunction

	function automatic result_t downlink_copy(input logic u, input header_t h,
			input logic last);
		return make_copy(ACT_FWD, u, ru_mac(u), ru_local_mac(u),
			swap_vid(h.has_vlan_tag, h.tag_control, ru_vid(u)), last);
	endfunction

	task automatic write_copy_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		case (idx)
			REG_MIDDLEBOX_MAC: regs_copy.middlebox_mac = data[MAC_W-1:0];
			REG_DU_MAC:        regs_copy.du_mac        = data[MAC_W-1:0];
			REG_DU_VLAN_ID:    regs_copy.du_vlan_id    = data[VID_W-1:0];
			REG_RU0_MAC:       regs_copy.ru0_mac       = data[MAC_W-1:0];
			REG_RU0_LOCAL_MAC: regs_copy.ru0_local_mac = data[MAC_W-1:0];
			REG_RU1_MAC:       regs_copy.ru1_mac       = data[MAC_W-1:0];
			REG_RU1_LOCAL_MAC: regs_copy.ru1_local_mac = data[MAC_W-1:0];
			REG_RU_MAPS:       regs_copy.ru_maps       = data;
			default: ;
		endcase
	endtask

	task automatic steer_header(input header_t h);
		logic [MAP_W-1:0] ant_bit;
		logic             u;
		ant_bit = 16'd1 << h.antenna_port;
		if (h.ingress_port == PORT_DU) begin
			if (h.source_mac != regs_copy.du_mac)
				copies_due.push_back(drop_copy(ACT_BAD_SRC, 1'b0, h));
			else if (h.dest_mac != regs_copy.middlebox_mac)
				copies_due.push_back(drop_copy(ACT_BAD_DST, 1'b0, h));
			else if (h.ecpri_msg_type == TYPE_RTC) begin
				copies_due.push_back(downlink_copy(1'b0, h, 1'b0));
				copies_due.push_back(downlink_copy(1'b1, h, 1'b1));
			end else if (h.ecpri_msg_type == TYPE_IQ) begin
				// first unit whose map holds the antenna wins
				if ((ru_antenna_map(1'b0) & ant_bit) != '0)
					copies_due.push_back(downlink_copy(1'b0, h, 1'b1));
				else if ((ru_antenna_map(1'b1) & ant_bit) != '0)
					copies_due.push_back(downlink_copy(1'b1, h, 1'b1));
				else
					copies_due.push_back(drop_copy(ACT_NO_ANT, 1'b0, h));
			end else
				copies_due.push_back(drop_copy(ACT_BAD_TYPE, 1'b0, h));
		end else if (h.ingress_port > NUM_UNITS) begin
			copies_due.push_back(drop_copy(ACT_BAD_SRC, 1'b0, h));
		end else begin
			u = (h.ingress_port != PORT_RU0);
			if (h.source_mac != ru_mac(u))
				copies_due.push_back(drop_copy(ACT_BAD_SRC, u, h));
			else if (h.dest_mac != ru_local_mac(u))
				copies_due.push_back(drop_copy(ACT_BAD_DST, u, h));
			else if ((ru_antenna_map(u) & ant_bit) == '0)
				copies_due.push_back(drop_copy(ACT_NO_ANT, u, h));
			else
				copies_due.push_back(make_copy(ACT_FWD, u, regs_copy.du_mac,
					regs_copy.middlebox_mac,
					swap_vid(h.has_vlan_tag, h.tag_control, regs_copy.du_vlan_id), 1'b1));
		end
	endtask

	task automatic report(input string msg);
		if (mismatches < PRINT_CAP)
			$display("%0t ns mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_copy(input result_t want, input result_t got);
		if (got.action !== want.action)
			report($sformatf("action %0d, want %0d", got.action, want.action));
		if (got.target_unit !== want.target_unit)
			report($sformatf("target_unit %0d, want %0d", got.target_unit, want.target_unit));
		if (got.new_dest_mac !== want.new_dest_mac)
			report($sformatf("new_dest_mac %h, want %h", got.new_dest_mac, want.new_dest_mac));
		if (got.new_source_mac !== want.new_source_mac)
			report($sformatf("new_source_mac %h, want %h",
				got.new_source_mac, want.new_source_mac));
		if (got.new_tag_control !== want.new_tag_control)
			report($sformatf("new_tag_control %h, want %h",
				got.new_tag_control, want.new_tag_control));
		if (got.last_copy !== want.last_copy)
			report($sformatf("last_copy %0d, want %0d", got.last_copy, want.last_copy));
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			regs_copy = '0;
			copies_due.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				write_copy_reg(cfg_index, cfg_data);
			if (start && !busy)
				steer_header(header);
			if (done) begin
				if (copies_due.size() == 0)
					report("result with no copy outstanding");
				else begin
					want = copies_due.pop_front();
					compare_copy(want, result);
				end
			end
		end
		pending    <= copies_due.size();
		fail_count <= mismatches;
	end

endmodule

// ===== bench/fronthaul_packet_steering_rewrite_test.sv =====
// Top of the steering testbench: clock, reset, register setup and header stimulus,
// with the verdict. Depends on fpsr_pkg, the steering block and fpsr_checker.
module fronthaul_packet_steering_rewrite_test;
	import fpsr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD     = 8;
	localparam int NUM_REGS   = REG_RU_MAPS + 1;
	localparam int SETTLE     = 4;
	localparam int IDLE_LIMIT = 400;
	localparam int PHASE_ITEMS = 80;
	localparam int RANDOM_CONFIGS = 5;

	// register setting for the directed part
	localparam logic [MAC_W-1:0] MB_A     = 48'h0200_0000_0001;
	localparam logic [MAC_W-1:0] DU_A     = 48'h0200_0000_00D0;
	localparam logic [MAC_W-1:0] RU0_A    = 48'h0200_0000_00A0;
	localparam logic [MAC_W-1:0] RU0_LC_A = 48'h0200_0000_00B0;
	localparam logic [MAC_W-1:0] RU1_A    = 48'h0200_0000_00A1;
	localparam logic [MAC_W-1:0] RU1_LC_A = 48'h0200_0000_00B1;
	localparam logic [MAC_W-1:0] ODD_MAC  = 48'h0A0B_0C0D_0E0F;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	header_t              header = '0;
	logic                 done;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   fail_count;
	int                   pending;

	logic [CFG_W-1:0] reg_val [NUM_REGS];
	int               burst_left = 0;
	int               idle_cycles = 0;

	fronthaul_packet_steering_rewrite DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.header    (header),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fpsr_checker steer_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.header     (header),
		.done       (done),
		.result     (result),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #(PERIOD / 2) clk = ~clk;

	// end the run if nothing moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[MAC_W-1:0];
	endfunction

	function automatic header_t build_header(input logic [1:0] port,
			input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
			input logic has_tag, input logic [TCI_W-1:0] tci,
			input logic [7:0] msg_type, input logic [3:0] ant);
		header_t h;
		h.ingress_port   = port;
		h.source_mac     = src;
		h.dest_mac       = dst;
		h.has_vlan_tag   = has_tag;
		h.tag_control    = tci;
		h.ecpri_msg_type = msg_type;
		h.antenna_port   = ant;
		return h;
	endfunction

	// mostly well-addressed headers for the current setting, some noise
	function automatic header_t make_header();
		header_t          h;
		int unsigned      roll;
		logic [MAC_W-1:0] good_src;
		logic [MAC_W-1:0] good_dst;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			h.ingress_port = PORT_DU;
		else if (roll < 72)
			h.ingress_port = PORT_RU0;
		else if (roll < 94)
			h.ingress_port = PORT_RU1;
		else
			h.ingress_port = PORT_NONE;
		case (h.ingress_port)
			PORT_RU0: begin
				good_src = reg_val[REG_RU0_MAC][MAC_W-1:0];
				good_dst = reg_val[REG_RU0_LOCAL_MAC][MAC_W-1:0];
			end
			PORT_RU1: begin
				good_src = reg_val[REG_RU1_MAC][MAC_W-1:0];
				good_dst = reg_val[REG_RU1_LOCAL_MAC][MAC_W-1:0];
			end
			default: begin
				good_src = reg_val[REG_DU_MAC][MAC_W-1:0];
				good_dst = reg_val[REG_MIDDLEBOX_MAC][MAC_W-1:0];
			end
		endcase
		h.source_mac   = ($urandom_range(0, 99) < 88) ? good_src : rand_mac();
		h.dest_mac     = ($urandom_range(0, 99) < 88) ? good_dst : rand_mac();
		h.has_vlan_tag = 1'($urandom_range(0, 1));
		h.tag_control  = 16'($urandom_range(0, 16'hFFFF));
		roll = $urandom_range(0, 99);
		if (roll < 40)
			h.ecpri_msg_type = TYPE_RTC;
		else if (roll < 80)
			h.ecpri_msg_type = TYPE_IQ;
		else
			h.ecpri_msg_type = 8'($urandom_range(0, 255));
		h.antenna_port = 4'($urandom_range(0, 15));
		return h;
	endfunction

	task automatic load_regs();
		for (int i = REG_MIDDLEBOX_MAC; i <= REG_RU_MAPS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data  <= reg_val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic randomize_regs();
		logic [63:0] r;
		reg_val[REG_MIDDLEBOX_MAC] = CFG_W'(rand_mac());
		reg_val[REG_DU_MAC]        = CFG_W'(rand_mac());
		reg_val[REG_DU_VLAN_ID]    = CFG_W'($urandom_range(0, 4095));
		reg_val[REG_RU0_MAC]       = CFG_W'(rand_mac());
		reg_val[REG_RU0_LOCAL_MAC] = CFG_W'(rand_mac());
		reg_val[REG_RU1_MAC]       = CFG_W'(rand_mac());
		reg_val[REG_RU1_LOCAL_MAC] = CFG_W'(rand_mac());
		// sometimes both units share addresses
		if ($urandom_range(0, 3) == 0)
			reg_val[REG_RU1_MAC] = reg_val[REG_RU0_MAC];
		if ($urandom_range(0, 3) == 0)
			reg_val[REG_RU1_LOCAL_MAC] = reg_val[REG_RU0_LOCAL_MAC];
		r = {$urandom, $urandom};
		reg_val[REG_RU_MAPS] = r[CFG_W-1:0];
	endtask

	// present one header, hold it until taken, then maybe open a gap
	task automatic send_header(input header_t h);
		start  <= 1'b1;
		header <= h;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 20);
		end else begin
			burst_left--;
		end
	endtask

	// stop sending and wait for every outstanding copy
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain();
			send_header(make_header());
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < NUM_REGS; i++)
			reg_val[i] = '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: all addresses zero, empty antenna maps
		send_header(build_header(PORT_DU, '0, '0, 1'b1, 16'hFFFF, TYPE_RTC, 4'd0));
		send_header(build_header(PORT_DU, '0, '0, 1'b0, 16'h0000, TYPE_IQ, 4'd15));
		send_header(build_header(PORT_RU0, '0, '0, 1'b1, 16'h5A5A, TYPE_IQ, 4'd3));
		drain();

		// directed setting: unit0 holds antennas 0 and 5, unit1 holds 4, 5 and 15
		reg_val[REG_MIDDLEBOX_MAC] = CFG_W'(MB_A);
		reg_val[REG_DU_MAC]        = CFG_W'(DU_A);
		reg_val[REG_DU_VLAN_ID]    = CFG_W'(12'h0AB);
		reg_val[REG_RU0_MAC]       = CFG_W'(RU0_A);
		reg_val[REG_RU0_LOCAL_MAC] = CFG_W'(RU0_LC_A);
		reg_val[REG_RU1_MAC]       = CFG_W'(RU1_A);
		reg_val[REG_RU1_LOCAL_MAC] = CFG_W'(RU1_LC_A);
		reg_val[REG_RU_MAPS]       = {12'hFFF, 16'h8030, 12'h001, 16'h0021};
		load_regs();
		send_header(build_header(PORT_DU, DU_A, MB_A, 1'b1, 16'hFFFF, TYPE_RTC, 4'd0));
		send_header(build_header(PORT_DU, DU_A, MB_A, 1'b0, 16'h1234, TYPE_RTC, 4'd9));
		send_header(build_header(PORT_DU, DU_A, MB_A, 1'b1, 16'h0000, TYPE_IQ, 4'd0));
		send_header(build_header(PORT_DU, DU_A, MB_A, 1'b1, 16'hE123, TYPE_IQ, 4'd5));
		send_header(build_header(PORT_DU, DU_A, MB_A, 1'b1, 16'h7FFF, TYPE_IQ, 4'd4));
		send_header(build_header(PORT_DU, DU_A, MB_A, 1'b0, 16'hBEEF, TYPE_IQ, 4'd15));
		send_header(build_header(PORT_DU, DU_A, MB_A, 1'b1, 16'h3456, TYPE_IQ, 4'd7));
		send_header(build_header(PORT_DU, ODD_MAC, MB_A, 1'b1, 16'h1111, TYPE_RTC, 4'd0));
		send_header(build_header(PORT_DU, DU_A, ODD_MAC, 1'b1, 16'h2222, TYPE_RTC, 4'd0));
		send_header(build_header(PORT_DU, DU_A, MB_A, 1'b1, 16'h3333, 8'd1, 4'd0));
		send_header(build_header(PORT_DU, DU_A, MB_A, 1'b0, 16'h4444, 8'hFF, 4'd15));
		send_header(build_header(PORT_RU0, RU0_A, RU0_LC_A, 1'b1, 16'h9876, TYPE_IQ, 4'd0));
		send_header(build_header(PORT_RU1, RU1_A, RU1_LC_A, 1'b1, 16'hFFFF, 8'hFF, 4'd15));
		send_header(build_header(PORT_RU0, ODD_MAC, RU0_LC_A, 1'b1, 16'h5555, TYPE_IQ, 4'd0));
		send_header(build_header(PORT_RU1, RU1_A, ODD_MAC, 1'b0, 16'h6666, TYPE_IQ, 4'd4));
		send_header(build_header(PORT_RU0, RU0_A, RU0_LC_A, 1'b1, 16'h7777, TYPE_IQ, 4'd4));
		send_header(build_header(PORT_NONE, DU_A, MB_A, 1'b1, 16'h8888, TYPE_RTC, 4'd0));
		send_header(build_header(PORT_RU1, RU1_A, RU1_LC_A, 1'b0, 16'hA5A5, TYPE_RTC, 4'd4));
		drain();

		// every register at its top value
		for (int i = 0; i < NUM_REGS; i++)
			reg_val[i] = {{(CFG_W - MAC_W){1'b0}}, {MAC_W{1'b1}}};
		reg_val[REG_DU_VLAN_ID] = {{(CFG_W - VID_W){1'b0}}, {VID_W{1'b1}}};
		reg_val[REG_RU_MAPS]    = '1;
		load_regs();
		run_random(PHASE_ITEMS);

		repeat (RANDOM_CONFIGS) begin
			randomize_regs();
			load_regs();
			run_random(PHASE_ITEMS);
		end

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
